>>> sv/sfas_pkg.sv
// Package with shared constants for the float add/sub/mul pipeline.
`default_nettype none
package sfas_pkg;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int FRAC_BITS = 23;
    localparam logic signed [9:0] EXP_BIAS = 10'sd127;
endpackage
`default_nettype wire

>>> sv/sfas_norm.sv
// Leading-one search and normalizing shift of a result magnitude.
`default_nettype none
module sfas_norm (
    input  wire logic [48:0] i_mag,
    input  wire logic [9:0]  i_exp,
    output logic      [22:0] o_frac,
    output logic      [7:0]  o_exp
);
    logic [5:0] msb;
    logic [48:0] shifted;
    logic [9:0] e_adj;

    always_comb begin
        msb = 6'd0;
        for (int k = 0; k < 49; k++) begin
            if (i_mag[k]) begin
                msb = 6'(k);
            end
        end
        if (msb >= 6'd23) begin
            shifted = i_mag >> (msb - 6'd23);
        end else begin
            shifted = i_mag << (6'd23 - msb);
        end
        e_adj  = i_exp + 10'(msb) - 10'd23 + 10'(sfas_pkg::EXP_BIAS);
        o_frac = shifted[22:0];
        o_exp  = e_adj[7:0];
    end
endmodule
`default_nettype wire

>>> sv/simple_float_add_sub_mul_top.sv
// Top level of the pipelined single-precision add, subtract and multiply unit.
`default_nettype none
// Three-stage pipeline: a request is taken in every cycle (busy is always low) and its
// result appears on o_result_bits with o_done high once it leaves stage three. Stage one
// unpacks and aligns or multiplies, stage two forms the sum and its magnitude, stage three
// normalizes and packs. The receiver cannot stall the pipeline.
module simple_float_add_sub_mul_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [31:0] i_a_bits,
    input  wire logic [31:0] i_b_bits,
    output logic             o_done,
    output logic      [31:0] o_result_bits
);
    logic        r_v1, r_v2, r_v3;
    logic signed [48:0] r_x1, r_y1;
    logic [9:0]  r_e1;
    logic [48:0] r_mag2;
    logic        r_sgn2, r_zero2;
    logic [9:0]  r_e2;
    logic [31:0] r_res3;

    logic        b_sign;
    logic [9:0]  ea, eb, n_e1;
    logic signed [24:0] ma, mb;
    logic [9:0]  dab, dba;
    logic [5:0]  sh;
    logic signed [48:0] n_x1, n_y1;
    logic signed [48:0] sum;
    logic [22:0] nf;
    logic [7:0]  ne;

    assign busy = 1'b0;

    always_comb begin
        b_sign = i_b_bits[31] ^ (i_opcode == sfas_pkg::OP_SUB);
        ea = 10'(i_a_bits[30:23]) - 10'(sfas_pkg::EXP_BIAS);
        eb = 10'(i_b_bits[30:23]) - 10'(sfas_pkg::EXP_BIAS);
        ma = i_a_bits[31] ? -$signed({2'b01, i_a_bits[22:0]}) : $signed({2'b01, i_a_bits[22:0]});
        mb = b_sign ? -$signed({2'b01, i_b_bits[22:0]}) : $signed({2'b01, i_b_bits[22:0]});
        dab = ea - eb;
        dba = eb - ea;
        sh = 6'd0;
        if (i_opcode[1]) begin
            n_x1 = 49'(ma * mb) >>> sfas_pkg::FRAC_BITS;
            n_y1 = 49'sd0;
            n_e1 = ea + eb;
        end else if ($signed(ea) < $signed(eb)) begin
            sh   = (dba > 10'd30) ? 6'd30 : dba[5:0];
            n_x1 = 49'(ma >>> sh);
            n_y1 = 49'(mb);
            n_e1 = eb;
        end else begin
            sh   = (dab > 10'd30) ? 6'd30 : dab[5:0];
            n_x1 = 49'(ma);
            n_y1 = 49'(mb >>> sh);
            n_e1 = ea;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_x1   <= n_x1;
        r_y1   <= n_y1;
        r_e1   <= n_e1;
        r_sgn2  <= sum[48];
        r_zero2 <= (sum == 49'sd0);
        r_mag2  <= sum[48] ? 49'(-sum) : 49'(sum);
        r_e2    <= r_e1;
        r_res3  <= r_zero2 ? 32'd0 : {r_sgn2, ne, nf};
    end

    assign sum = r_x1 + r_y1;

    sfas_norm u_norm (
        .i_mag  (r_mag2),
        .i_exp  (r_e2),
        .o_frac (nf),
        .o_exp  (ne)
    );

    assign o_done        = r_v3;
    assign o_result_bits = r_res3;
endmodule
`default_nettype wire

>>> sv/sfas_checker.sv
// Port-level checker for the float pipeline, bound to the top level.
`default_nettype none
module sfas_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic [31:0] o_result_bits
);
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##2 o_done) else $error("missing result");
    a_nospur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 3)) else $error("spurious result");
    a_busy: assert property (@(posedge i_clk) !busy) else $error("busy raised");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_result_bits)) else $error("unknown result");
endmodule
bind simple_float_add_sub_mul_top sfas_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_result_bits(o_result_bits)
);
`default_nettype wire
